// ===== rtl/lsvm_pkg.sv =====
// Shared constants, operation codes and a helper function of the voice mixer.
package lsvm_pkg;

  // Number of voices and depth of the sample store (a power of two).
  localparam int VOICES       = 16;
  localparam int SAMPLE_DEPTH = 65536;

  localparam int VOICE_W  = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int MEM_AW   = $clog2(SAMPLE_DEPTH);

  localparam int SAMPLE_W = 16;
  localparam int POS_W    = 16;
  localparam int PHASE_W  = 16;
  localparam int RATIO_W  = 24;
  localparam int TOTAL_W  = RATIO_W + 1;
  localparam int STEP_W   = TOTAL_W - PHASE_W;
  localparam int MIX_W    = 21;

  // Width of the interpolation working value and of the shared product.
  localparam int S_W      = 23;
  localparam int PROD_W   = S_W + PHASE_W + 1;
  localparam int ACC_W    = S_W + VOICE_W + 1;

  localparam int MIX_MAX  = 1048575;
  localparam int MIX_MIN  = -1048576;
  localparam int RND_HALF = 32768;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_NOTE_ON = 2'd1,
    OP_TICK    = 2'd2
  } op_e;

  // Reduce a 16-bit sample address onto the sample store.
  function automatic logic [MEM_AW-1:0] mem_index(input logic [POS_W-1:0] a);
    return MEM_AW'(a);
  endfunction

endpackage

// ===== rtl/lsvm_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module lsvm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/looped_sample_voice_mixer.sv =====
// Sixteen-voice looped sample player with cubic Hermite interpolation and saturated mix.
// Load and note-on beats are completed without leaving the idle state.
// A tick visits every voice in turn; a silent voice is skipped, while an enabled voice's time is
// set by four reads of the single sample read port and three passes through one multiplier.
// No new beat is taken while a tick is in progress; the result register frees the input side.
// Reset clears all voice state and silences every voice; sample memory is not cleared.
module looped_sample_voice_mixer (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [1:0]                            operation_i,
  input  logic [3:0]                            voice_i,
  input  logic [lsvm_pkg::POS_W-1:0]            address_i,
  input  logic signed [lsvm_pkg::SAMPLE_W-1:0]  sample_value_i,
  input  logic [lsvm_pkg::POS_W-1:0]            loop_start_i,
  input  logic [lsvm_pkg::POS_W-1:0]            loop_end_i,
  input  logic [lsvm_pkg::RATIO_W-1:0]          ratio_i,
  input  logic                                  enable_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [lsvm_pkg::MIX_W-1:0]     mix_sample_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_VOICE, S_RD0, S_RD1, S_RD2, S_RD3, S_CAP, S_COEF1, S_COEF2,
    S_M1, S_R1, S_M2, S_R2, S_M3, S_R3, S_ACC, S_DONE
  } state_e;

  localparam int SW = lsvm_pkg::S_W;
  localparam int PW = lsvm_pkg::PROD_W;
  localparam int AW = lsvm_pkg::ACC_W;
  localparam int VW = lsvm_pkg::VOICE_W;
  localparam int NV = lsvm_pkg::VOICES;

  state_e state_q;

  // Per-voice state.
  logic [lsvm_pkg::POS_W-1:0]   pos_q   [NV];
  logic [lsvm_pkg::PHASE_W-1:0] phase_q [NV];
  logic [lsvm_pkg::POS_W-1:0]   ls_q    [NV];
  logic [lsvm_pkg::POS_W-1:0]   le_q    [NV];
  logic [lsvm_pkg::RATIO_W-1:0] ratio_q [NV];
  logic [NV-1:0]                en_q;

  // Working registers of the sequencer.
  logic [VW-1:0]                      k_q;
  logic signed [lsvm_pkg::SAMPLE_W-1:0] xm1_q, x0_q, x1_q, x2_q;
  logic signed [SW-1:0]               c_q, v_q, e_q, w_q, b_q, s_q;
  logic signed [PW-1:0]               prod_q;
  logic [lsvm_pkg::PHASE_W-1:0]       t_q;
  logic [lsvm_pkg::TOTAL_W-1:0]       total_q;
  logic [lsvm_pkg::POS_W:0]           nxt_pos_q;
  logic [lsvm_pkg::POS_W-1:0]         span_q;
  logic                               wrap_en_q;
  logic signed [AW-1:0]               mix_acc_q;
  logic                               out_valid_q;
  logic signed [lsvm_pkg::MIX_W-1:0]  mix_q;

  logic                               in_acc;
  logic                               out_acc;
  logic                               note_ok;
  logic [VW-1:0]                      note_idx;
  logic [lsvm_pkg::POS_W-1:0]         cur_pos;
  logic [lsvm_pkg::POS_W-1:0]         rd_pos;
  logic [lsvm_pkg::SAMPLE_W-1:0]      rdata;
  logic                               ram_we;
  logic signed [PW-1:0]               prod_rnd;
  logic signed [SW-1:0]               rnd;
  logic signed [SW-1:0]               addend;
  logic signed [SW-1:0]               rnd_sum;
  logic signed [SW-1:0]               half;
  logic signed [lsvm_pkg::MIX_W-1:0]  mix_sat;
  logic [lsvm_pkg::POS_W:0]           wrapped;
  logic                               last_voice;

  assign in_stall_o   = (state_q != S_IDLE);
  assign in_acc       = in_valid_i && !in_stall_o;
  assign out_valid_o  = out_valid_q;
  assign out_acc      = out_valid_q && !out_stall_i;
  assign mix_sample_o = mix_q;

  assign note_ok    = (32'(voice_i) < NV);
  assign note_idx   = VW'(voice_i);
  assign cur_pos    = pos_q[k_q];
  assign last_voice = (k_q == VW'(NV - 1));

  assign ram_we = in_acc && (operation_i == lsvm_pkg::OP_LOAD);

  // The four neighbours are read at position-1 .. position+2, wrapping in 16 bits.
  always_comb begin
    case (state_q)
      S_RD0:   rd_pos = cur_pos - lsvm_pkg::POS_W'(1);
      S_RD2:   rd_pos = cur_pos + lsvm_pkg::POS_W'(1);
      S_RD3:   rd_pos = cur_pos + lsvm_pkg::POS_W'(2);
      default: rd_pos = cur_pos;
    endcase
  end

  lsvm_ram #(
    .WIDTH (lsvm_pkg::SAMPLE_W),
    .DEPTH (lsvm_pkg::SAMPLE_DEPTH)
  ) u_sample_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (lsvm_pkg::mem_index(address_i)),
    .wdata_i (sample_value_i),
    .raddr_i (lsvm_pkg::mem_index(rd_pos)),
    .rdata_o (rdata)
  );

  // Shared rounding adder: round the product to Q16 and add the step's addend.
  assign prod_rnd = prod_q + PW'(lsvm_pkg::RND_HALF);
  assign rnd      = SW'(prod_rnd >>> 16);

  always_comb begin
    case (state_q)
      S_R1:    addend = -b_q;
      S_R2:    addend = c_q;
      default: addend = SW'(x0_q) <<< 1;
    endcase
  end

  assign rnd_sum = rnd + addend;
  assign half    = (s_q + SW'(1)) >>> 1;
  assign wrapped = nxt_pos_q - {1'b0, span_q};

  always_comb begin
    if (mix_acc_q > AW'(lsvm_pkg::MIX_MAX)) begin
      mix_sat = lsvm_pkg::MIX_W'(lsvm_pkg::MIX_MAX);
    end else if (mix_acc_q < AW'(lsvm_pkg::MIX_MIN)) begin
      mix_sat = lsvm_pkg::MIX_W'(lsvm_pkg::MIX_MIN);
    end else begin
      mix_sat = lsvm_pkg::MIX_W'(mix_acc_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      for (int i = 0; i < NV; i++) begin
        pos_q[i]   <= '0;
        phase_q[i] <= '0;
        ls_q[i]    <= '0;
        le_q[i]    <= '0;
        ratio_q[i] <= '0;
      end
      en_q        <= '0;
      k_q         <= '0;
      xm1_q       <= '0;
      x0_q        <= '0;
      x1_q        <= '0;
      x2_q        <= '0;
      c_q         <= '0;
      v_q         <= '0;
      e_q         <= '0;
      w_q         <= '0;
      b_q         <= '0;
      s_q         <= '0;
      prod_q      <= '0;
      t_q         <= '0;
      total_q     <= '0;
      nxt_pos_q   <= '0;
      span_q      <= '0;
      wrap_en_q   <= 1'b0;
      mix_acc_q   <= '0;
      out_valid_q <= 1'b0;
      mix_q       <= '0;
    end else begin
      if ((state_q == S_DONE) && (!out_valid_q || !out_stall_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_acc) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            case (operation_i)
              lsvm_pkg::OP_NOTE_ON: begin
                if (note_ok) begin
                  pos_q[note_idx]   <= address_i;
                  phase_q[note_idx] <= '0;
                  ls_q[note_idx]    <= loop_start_i;
                  le_q[note_idx]    <= loop_end_i;
                  ratio_q[note_idx] <= ratio_i;
                  en_q[note_idx]    <= enable_i;
                end
              end
              lsvm_pkg::OP_TICK: begin
                k_q       <= '0;
                mix_acc_q <= '0;
                state_q   <= S_VOICE;
              end
              default: ;
            endcase
          end
        end
        S_VOICE: begin
          if (en_q[k_q]) begin
            state_q <= S_RD0;
          end else if (last_voice) begin
            state_q <= S_DONE;
          end else begin
            k_q <= k_q + VW'(1);
          end
        end
        S_RD0: begin
          t_q     <= phase_q[k_q];
          total_q <= lsvm_pkg::TOTAL_W'(phase_q[k_q]) + lsvm_pkg::TOTAL_W'(ratio_q[k_q]);
          state_q <= S_RD1;
        end
        S_RD1: begin
          xm1_q     <= rdata;
          nxt_pos_q <= {1'b0, cur_pos}
                       + (lsvm_pkg::POS_W + 1)'(total_q[lsvm_pkg::TOTAL_W-1:lsvm_pkg::PHASE_W]);
          span_q    <= le_q[k_q] - ls_q[k_q];
          wrap_en_q <= (le_q[k_q] > ls_q[k_q]);
          state_q   <= S_RD2;
        end
        S_RD2: begin
          x0_q    <= rdata;
          state_q <= S_RD3;
        end
        S_RD3: begin
          x1_q    <= rdata;
          state_q <= S_CAP;
        end
        S_CAP: begin
          x2_q    <= rdata;
          state_q <= S_COEF1;
        end
        S_COEF1: begin
          c_q     <= SW'(x1_q) - SW'(xm1_q);
          v_q     <= (SW'(x0_q) - SW'(x1_q)) <<< 1;
          e_q     <= SW'(x2_q) - SW'(x0_q);
          state_q <= S_COEF2;
        end
        S_COEF2: begin
          s_q     <= c_q + (v_q <<< 1) + e_q;
          w_q     <= c_q + v_q;
          state_q <= S_M1;
        end
        S_M1, S_M2, S_M3: begin
          prod_q <= PW'(s_q) * PW'($signed({1'b0, t_q}));
          if (state_q == S_M1) begin
            b_q <= w_q + s_q;
          end
          case (state_q)
            S_M1:    state_q <= S_R1;
            S_M2:    state_q <= S_R2;
            default: state_q <= S_R3;
          endcase
        end
        S_R1, S_R2, S_R3: begin
          s_q <= rnd_sum;
          case (state_q)
            S_R1:    state_q <= S_M2;
            S_R2:    state_q <= S_M3;
            default: state_q <= S_ACC;
          endcase
        end
        S_ACC: begin
          mix_acc_q    <= mix_acc_q + AW'(half);
          phase_q[k_q] <= total_q[lsvm_pkg::PHASE_W-1:0];
          // Wrap back once by the loop length when the loop is non-empty.
          if (wrap_en_q && (nxt_pos_q >= {1'b0, le_q[k_q]})) begin
            pos_q[k_q] <= wrapped[lsvm_pkg::POS_W-1:0];
          end else begin
            pos_q[k_q] <= nxt_pos_q[lsvm_pkg::POS_W-1:0];
          end
          if (last_voice) begin
            state_q <= S_DONE;
          end else begin
            k_q     <= k_q + VW'(1);
            state_q <= S_VOICE;
          end
        end
        S_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            mix_q   <= mix_sat;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== tb/looped_sample_voice_mixer_tb.sv =====
// Self-checking voice mixer testbench: directed rows, then random beats with idling and stalls.
module looped_sample_voice_mixer_tb;

  localparam logic [1:0] OP_RESERVED = 2'd3;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int TAIL_CYCLES = 300;
  localparam int LONG_HOLD   = 800;
  localparam int PHASE_BEATS = 165;
  localparam int FILL_AT     = 4;
  // This window of the store is filled in full at FILL_AT, and enabled voices never read outside it.
  localparam logic [15:0] WIN_BASE = 16'hFF00;
  localparam int WIN_SIZE = 512;

  typedef struct {
    logic [1:0]                           op;
    logic [lsvm_pkg::VOICE_W-1:0]         voice;
    logic [lsvm_pkg::POS_W-1:0]           address;
    logic signed [lsvm_pkg::SAMPLE_W-1:0] sample;
    logic [lsvm_pkg::POS_W-1:0]           loop_start;
    logic [lsvm_pkg::POS_W-1:0]           loop_end;
    logic [lsvm_pkg::RATIO_W-1:0]         ratio;
    logic                                 enable;
    logic                                 typed;
    logic signed [lsvm_pkg::MIX_W-1:0]    typed_mix;
  } mixer_beat_t;

  logic                                 clk_i = 1'b0;
  logic                                 rst_ni = 1'b0;
  logic                                 in_valid_i = 1'b0;
  logic                                 in_stall_o;
  logic [1:0]                           operation_i = 2'd0;
  logic [3:0]                           voice_i = 4'd0;
  logic [lsvm_pkg::POS_W-1:0]           address_i = '0;
  logic signed [lsvm_pkg::SAMPLE_W-1:0] sample_value_i = '0;
  logic [lsvm_pkg::POS_W-1:0]           loop_start_i = '0;
  logic [lsvm_pkg::POS_W-1:0]           loop_end_i = '0;
  logic [lsvm_pkg::RATIO_W-1:0]         ratio_i = '0;
  logic                                 enable_i = 1'b0;
  logic                                 out_valid_o;
  logic                                 out_stall_i = 1'b0;
  logic signed [lsvm_pkg::MIX_W-1:0]    mix_sample_o;

  // Mirror of the block's sample store and voice registers.
  logic signed [lsvm_pkg::SAMPLE_W-1:0] wave_mem [0:lsvm_pkg::SAMPLE_DEPTH-1];
  logic [lsvm_pkg::POS_W-1:0]           v_pos [lsvm_pkg::VOICES];
  logic [lsvm_pkg::PHASE_W-1:0]         v_phase [lsvm_pkg::VOICES];
  logic [lsvm_pkg::POS_W-1:0]           v_ls [lsvm_pkg::VOICES];
  logic [lsvm_pkg::POS_W-1:0]           v_le [lsvm_pkg::VOICES];
  logic [lsvm_pkg::RATIO_W-1:0]         v_ratio [lsvm_pkg::VOICES];
  logic                                 v_on [lsvm_pkg::VOICES];

  logic signed [lsvm_pkg::MIX_W-1:0]    mix_expected_q [$];
  logic signed [lsvm_pkg::MIX_W-1:0]    mix_want;
  mixer_beat_t                          directed_rows [$];
  int                                   fail_count = 0;
  int                                   cycle_count = 0;
  int                                   send_idle_pct = 0;
  int                                   recv_stall_pct = 0;
  int                                   hold_requests = 0;

  looped_sample_voice_mixer dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .operation_i    (operation_i),
    .voice_i        (voice_i),
    .address_i      (address_i),
    .sample_value_i (sample_value_i),
    .loop_start_i   (loop_start_i),
    .loop_end_i     (loop_end_i),
    .ratio_i        (ratio_i),
    .enable_i       (enable_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .mix_sample_o   (mix_sample_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint signed q16_round(longint signed p);
    return (p + lsvm_pkg::RND_HALF) >>> lsvm_pkg::PHASE_W;
  endfunction

  // Four-point Hermite curve evaluated in Horner form at phase t (Q0.16).
  function automatic longint signed hermite_point(longint signed t, longint signed xm1,
                                                  longint signed x0, longint signed x1,
                                                  longint signed x2);
    longint signed c, v, w, a, b, s;
    c = x1 - xm1;
    v = 2 * (x0 - x1);
    w = c + v;
    a = w + v + x2 - x0;
    b = w + a;
    s = q16_round(a * t) - b;
    s = q16_round(s * t) + c;
    s = q16_round(s * t) + 2 * x0;
    return (s + 1) >>> 1;
  endfunction

  task automatic advance_mixer(input mixer_beat_t b, output bit ticked,
                               output logic signed [lsvm_pkg::MIX_W-1:0] mix);
    longint signed acc;
    logic [lsvm_pkg::POS_W-1:0] p;
    logic [lsvm_pkg::TOTAL_W-1:0] total;
    logic [31:0] pos;
    ticked = 1'b0;
    mix = '0;
    acc = 0;
    case (b.op)
      lsvm_pkg::OP_LOAD: wave_mem[b.address] = b.sample;
      lsvm_pkg::OP_NOTE_ON: begin
        if (b.voice < lsvm_pkg::VOICES) begin
          v_pos[b.voice]   = b.address;
          v_phase[b.voice] = '0;
          v_ls[b.voice]    = b.loop_start;
          v_le[b.voice]    = b.loop_end;
          v_ratio[b.voice] = b.ratio;
          v_on[b.voice]    = b.enable;
        end
      end
      lsvm_pkg::OP_TICK: begin
        ticked = 1'b1;
        for (int k = 0; k < lsvm_pkg::VOICES; k++) begin
          if (v_on[k]) begin
            p = v_pos[k];
            acc += hermite_point(longint'(v_phase[k]), wave_mem[p - 16'd1], wave_mem[p],
                                 wave_mem[p + 16'd1], wave_mem[p + 16'd2]);
            total = lsvm_pkg::TOTAL_W'(v_phase[k]) + lsvm_pkg::TOTAL_W'(v_ratio[k]);
            pos = 32'(v_pos[k]) + 32'(total[lsvm_pkg::TOTAL_W-1:lsvm_pkg::PHASE_W]);
            v_phase[k] = total[lsvm_pkg::PHASE_W-1:0];
            // The loop only applies when it has a positive length.
            if (v_le[k] > v_ls[k] && pos >= 32'(v_le[k]))
              pos = pos - (32'(v_le[k]) - 32'(v_ls[k]));
            v_pos[k] = pos[lsvm_pkg::POS_W-1:0];
          end
        end
        if (acc > lsvm_pkg::MIX_MAX) acc = lsvm_pkg::MIX_MAX;
        if (acc < lsvm_pkg::MIX_MIN) acc = lsvm_pkg::MIX_MIN;
        mix = lsvm_pkg::MIX_W'(acc);
      end
      default: ;
    endcase
  endtask

  function automatic mixer_beat_t mk_beat(logic [1:0] op, logic [3:0] voice,
                                          logic [15:0] address, logic [15:0] sample,
                                          logic [15:0] ls, logic [15:0] le,
                                          logic [23:0] ratio, logic en, logic typed,
                                          logic signed [lsvm_pkg::MIX_W-1:0] typed_mix);
    mixer_beat_t b;
    b.op = op;
    b.voice = voice;
    b.address = address;
    b.sample = sample;
    b.loop_start = ls;
    b.loop_end = le;
    b.ratio = ratio;
    b.enable = en;
    b.typed = typed;
    b.typed_mix = typed_mix;
    return b;
  endfunction

  function automatic mixer_beat_t tick_row(logic typed,
                                           logic signed [lsvm_pkg::MIX_W-1:0] typed_mix);
    return mk_beat(lsvm_pkg::OP_TICK, 4'd0, 16'd0, 16'd0, 16'd0, 16'd0, 24'd0, 1'b0,
                   typed, typed_mix);
  endfunction

  function automatic mixer_beat_t note_row(logic [3:0] voice, logic [15:0] address,
                                           logic [15:0] ls, logic [15:0] le,
                                           logic [23:0] ratio, logic en);
    return mk_beat(lsvm_pkg::OP_NOTE_ON, voice, address, 16'd0, ls, le, ratio, en,
                   1'b0, '0);
  endfunction

  function automatic mixer_beat_t load_row(logic [15:0] address, logic [15:0] sample);
    return mk_beat(lsvm_pkg::OP_LOAD, 4'd0, address, sample, 16'd0, 16'd0, 24'd0, 1'b0,
                   1'b0, '0);
  endfunction

  function automatic mixer_beat_t random_beat();
    mixer_beat_t b;
    int unsigned pick;
    int unsigned span;
    b = mk_beat(2'($urandom), 4'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                16'($urandom), 24'($urandom), 1'($urandom), 1'b0, '0);
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      b.op = lsvm_pkg::OP_LOAD;
    end else if (pick < 45) begin
      b.op = lsvm_pkg::OP_NOTE_ON;
      b.enable = ($urandom_range(0, 3) != 0);
      // A silent voice keeps any fields; a sounding one stays inside the filled window.
      if (b.enable) begin
        case ($urandom_range(0, 2))
          0, 1: begin
            span = $urandom_range(1, 100);
            b.loop_start = (($urandom_range(0, 1) != 0) ? 16'h0001 : 16'hFF01)
                           + 16'($urandom_range(0, 100));
            b.loop_end   = b.loop_start + 16'(span);
            b.address    = b.loop_start + 16'($urandom_range(0, span - 1));
            // A step of at most one loop length keeps the position inside the loop.
            if ($urandom_range(0, 3) == 0)
              b.ratio = 24'((span << 16) - 1);
            else
              b.ratio = 24'($urandom_range(0, (span << 16) - 1));
          end
          default: begin
            // Without a loop the voice has to stand still.
            b.loop_end   = 16'($urandom_range(0, 32768));
            b.loop_start = b.loop_end + 16'($urandom_range(0, 5000));
            b.address    = WIN_BASE + 16'($urandom_range(1, WIN_SIZE - 3));
            b.ratio      = '0;
          end
        endcase
      end
    end else if (pick < 95) begin
      b.op = lsvm_pkg::OP_TICK;
    end else begin
      b.op = OP_RESERVED;
    end
    return b;
  endfunction

  // Offers one beat, idling first at the sender's current rate, and books its result.
  task automatic offer_beat(input mixer_beat_t b);
    bit ticked;
    logic signed [lsvm_pkg::MIX_W-1:0] mix;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    operation_i    <= b.op;
    voice_i        <= b.voice;
    address_i      <= b.address;
    sample_value_i <= b.sample;
    loop_start_i   <= b.loop_start;
    loop_end_i     <= b.loop_end;
    ratio_i        <= b.ratio;
    enable_i       <= b.enable;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    advance_mixer(b, ticked, mix);
    if (ticked) mix_expected_q.push_back(b.typed ? b.typed_mix : mix);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (mix_expected_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic random_phase(input int idle_pct, input int stall_pct, input bit long_hold);
    mixer_beat_t b;
    int n;
    n = 0;
    send_idle_pct = idle_pct;
    recv_stall_pct <= stall_pct;
    while (n < PHASE_BEATS) begin
      // A long hold-off with the sender still busy makes the block back up.
      if (long_hold && n == 100) hold_requests <= hold_requests + 1;
      b = random_beat();
      offer_beat(b);
      if (b.op != OP_RESERVED) n++;
    end
  endtask

  initial begin : stimulus
    for (int k = 0; k < lsvm_pkg::VOICES; k++) begin
      v_pos[k] = '0;
      v_phase[k] = '0;
      v_ls[k] = '0;
      v_le[k] = '0;
      v_ratio[k] = '0;
      v_on[k] = 1'b0;
    end

    // Rows ahead of the window fill never read samples; the rest stay inside the window.
    directed_rows.push_back(tick_row(1'b1, 21'sd0));
    directed_rows.push_back(mk_beat(OP_RESERVED, 4'hF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                    16'hFFFF, 24'hFFFFFF, 1'b1, 1'b0, '0));
    directed_rows.push_back(note_row(4'd15, 16'd100, 16'd0, 16'd0, 24'hFFFFFF, 1'b0));
    directed_rows.push_back(tick_row(1'b1, 21'sd0));
    directed_rows.push_back(load_row(16'h0000, 16'h7FFF));
    directed_rows.push_back(load_row(16'hFFFF, 16'h8000));
    directed_rows.push_back(note_row(4'd0, 16'h0000, 16'd0, 16'd0, 24'd0, 1'b1));
    directed_rows.push_back(tick_row(1'b1, 21'sd32767));
    directed_rows.push_back(tick_row(1'b1, 21'sd32767));
    directed_rows.push_back(note_row(4'd0, 16'hFFFF, 16'd0, 16'd0, 24'd0, 1'b1));
    directed_rows.push_back(tick_row(1'b1, -21'sd32768));
    directed_rows.push_back(note_row(4'd0, 16'hFFFE, 16'd10, 16'hFFFF, 24'h018000, 1'b1));
    directed_rows.push_back(tick_row(1'b0, '0));
    directed_rows.push_back(tick_row(1'b0, '0));
    directed_rows.push_back(tick_row(1'b0, '0));
    directed_rows.push_back(note_row(4'd1, 16'hFF01, 16'd200, 16'd100, 24'hFFFFFF, 1'b1));
    directed_rows.push_back(tick_row(1'b0, '0));
    directed_rows.push_back(tick_row(1'b0, '0));
    directed_rows.push_back(note_row(4'd1, 16'h0000, 16'd0, 16'd0, 24'd0, 1'b0));
    directed_rows.push_back(note_row(4'd15, 16'h0040, 16'h0040, 16'h0042, 24'h00C000, 1'b1));
    directed_rows.push_back(tick_row(1'b0, '0));
    directed_rows.push_back(tick_row(1'b0, '0));
    directed_rows.push_back(note_row(4'd0, 16'd0, 16'd0, 16'd0, 24'd0, 1'b0));
    directed_rows.push_back(tick_row(1'b0, '0));
    directed_rows.push_back(load_row(16'h8000, 16'h5555));

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < directed_rows.size(); i++) begin
      if (i == FILL_AT) begin
        for (int a = 0; a < WIN_SIZE; a++)
          offer_beat(load_row(16'(WIN_BASE + a), 16'($urandom)));
      end
      offer_beat(directed_rows[i]);
    end
    drain_results();

    random_phase(0, 0, 1'b1);
    drain_results();
    random_phase(49, 0, 1'b0);
    drain_results();
    random_phase(0, 49, 1'b0);
    drain_results();
    random_phase(8, 8, 1'b0);

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mix_expected_q.size() != 0) begin
      $error("mix_sample: %0d expected beats never arrived", mix_expected_q.size());
      fail_count++;
    end
    if (fail_count == 0)
      $display("** looped_sample_voice_mixer: PASSED **");
    else
      $display("** looped_sample_voice_mixer: FAILED **");
    $finish;
  end

  initial begin : result_sink
    int hold_left;
    int holds_done;
    hold_left = 0;
    holds_done = 0;
    forever begin
      @(posedge clk_i);
      if (hold_requests != holds_done) begin
        holds_done = hold_requests;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (mix_expected_q.size() == 0) begin
        $error("mix_sample: unexpected beat with value %0d", mix_sample_o);
        fail_count++;
      end else begin
        mix_want = mix_expected_q.pop_front();
        if (mix_sample_o !== mix_want) begin
          $error("mix_sample: expected %0d, got %0d", mix_want, mix_sample_o);
          fail_count++;
        end
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("** looped_sample_voice_mixer: FAILED **");
    $finish;
  end

endmodule
